FILE: sv/bbf_pkg.sv
// Shared types, codes and helpers for the bit-select Bloom filter.
package bbf_pkg;

    localparam int SPAN      = 30;
    localparam int KIND_W    = 2;
    localparam int HC_W      = 4;
    localparam int SKIP_W    = 6;
    localparam int OUT_CNT_W = 11;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int POS_W     = 5;
    localparam int SUM_W     = 9;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [1:0] REG_HASH_COUNT  = 2'd0;
    localparam logic [1:0] REG_SKIP_BITS   = 2'd1;
    localparam logic [1:0] REG_BANKED_MODE = 2'd2;

    typedef struct packed {
        logic [HC_W-1:0]   hash_count;
        logic [SKIP_W-1:0] skip_bits;
        logic              banked_mode;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_HASH,
        S_READ,
        S_CHECK,
        S_DONE
    } t_state;

    // t mod 30 for t below 270: parallel compares against the multiples
    function automatic logic [POS_W-1:0] span_mod(input logic [SUM_W-1:0] t);
        logic [SUM_W-1:0] r;
        r = t;
        for (int m = 1; m <= 8; m++) begin
            if (t >= SUM_W'(SPAN * m)) begin
                r = t - SUM_W'(SPAN * m);
            end
        end
        return r[POS_W-1:0];
    endfunction

endpackage

FILE: sv/bbf_in_if.sv
// Input item channel: operation kind and cache line number.
interface bbf_in_if #(
    parameter int LINE_BITS = 58
);
    import bbf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [LINE_BITS-1:0] line_number;

    modport source (output valid, output kind, output line_number, input ready);
    modport sink   (input valid, input kind, input line_number, output ready);
endinterface

FILE: sv/bbf_out_if.sv
// Result item channel: query answer and population count.
interface bbf_out_if;
    import bbf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 maybe_present;
    logic [OUT_CNT_W-1:0] set_bit_count;

    modport source (output valid, output maybe_present, output set_bit_count, input ready);
    modport sink   (input valid, input maybe_present, input set_bit_count, output ready);
endinterface

FILE: sv/bbf_bitmem.sv
// Single-port filter bit memory with registered read data.
module bbf_bitmem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic          i_wdata,
    output logic          o_rdata
);
    logic r_mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/bbf_cfg.sv
// APB-style configuration registers.
module bbf_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bbf_pkg::PADDR_W-1:0]  paddr,
    input  logic [bbf_pkg::PDATA_W-1:0]  pwdata,
    output logic [bbf_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output bbf_pkg::t_cfg                o_cfg
);
    import bbf_pkg::*;

    t_cfg       r_cfg;
    logic       wr;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1:2];
    assign wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hash_count  <= HC_W'(1);
            r_cfg.skip_bits   <= '0;
            r_cfg.banked_mode <= 1'b0;
        end else if (wr) begin
            unique case (reg_sel)
                REG_HASH_COUNT:  r_cfg.hash_count  <= pwdata[HC_W-1:0];
                REG_SKIP_BITS:   r_cfg.skip_bits   <= pwdata[SKIP_W-1:0];
                REG_BANKED_MODE: r_cfg.banked_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_HASH_COUNT:  prdata = PDATA_W'(r_cfg.hash_count);
            REG_SKIP_BITS:   prdata = PDATA_W'(r_cfg.skip_bits);
            REG_BANKED_MODE: prdata = PDATA_W'(r_cfg.banked_mode);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule

FILE: sv/bbf_index.sv
// Hash index generator: bit-select stage, then bank reduction.
module bbf_index #(
    parameter int IDX_BITS = 10,
    parameter int AW       = 10,
    parameter int KW       = 4,
    parameter int PB       = 11,
    parameter int QB       = 4
) (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic [bbf_pkg::SPAN-1:0]     i_v30,
    input  logic [KW-1:0]                i_h,
    input  logic [KW-1:0]                i_k,
    input  logic [PB-1:0]                i_part,
    input  logic [PB-1:0]                i_base,
    input  logic                         i_banked,
    output logic [AW-1:0]                o_idx
);
    import bbf_pkg::*;

    localparam int RW = PB + QB;

    logic [IDX_BITS-1:0] n_y;
    logic [IDX_BITS-1:0] r_y;
    logic [RW-1:0]       rem;
    logic [RW-1:0]       sum;

    always_comb begin
        logic [SUM_W-1:0] t;
        logic [POS_W-1:0] pos;
        n_y = '0;
        for (int j = 0; j < IDX_BITS; j++) begin
            t      = SUM_W'(i_h) + SUM_W'(i_k) * SUM_W'(j);
            pos    = span_mod(t);
            n_y[j] = i_v30[pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_y <= n_y;
        end
    end

    // quotient is below 2k, so QB restoring steps leave the remainder
    always_comb begin
        logic [RW-1:0] sub;
        rem = RW'(r_y);
        for (int s = QB - 1; s >= 0; s--) begin
            sub = RW'(i_part) << s;
            if (rem >= sub) begin
                rem = rem - sub;
            end
        end
        sum = rem + RW'(i_base);
    end

    assign o_idx = i_banked ? sum[AW-1:0] : AW'(r_y);
endmodule

FILE: sv/bitselect_bloom_filter_unit.sv
// Bit-select Bloom filter over cache line numbers: top level and sequencer.
//
// Items arrive on i_item (kind, line_number) and are taken when valid and
// ready are high at a rising edge; each gives one result on o_result
// (maybe_present, set_bit_count). Configuration goes through the APB port
// at byte addresses 0, 4 and 8 (hash_count, skip_bits, banked_mode).
// Items are worked one at a time through a single-port bit memory.
// Insert and query: each hash passes the select, read and check states in turn;
// after the last check the result register loads from the done state once it
// is free, and the next item is taken after that.
// Zero hashes and unused kinds go straight to the done state. A clear writes
// the memory one bit a cycle. After reset the same clearing pass runs with
// ready low; configuration writes are taken throughout.
// The result register holds until taken. A new item is still accepted while
// it waits; that item then holds its result until the register frees.
module bitselect_bloom_filter_unit #(
    parameter int FILTER_SIZE = 1024,
    parameter int MAX_HASHES  = 8,
    parameter int LINE_BITS   = 58
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bbf_in_if.sink                       i_item,
    bbf_out_if.source                    o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bbf_pkg::PADDR_W-1:0]  paddr,
    input  logic [bbf_pkg::PDATA_W-1:0]  pwdata,
    output logic [bbf_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import bbf_pkg::*;

    localparam int IDX_BITS = $clog2(FILTER_SIZE + 1) - 1;
    localparam int AW       = $clog2(FILTER_SIZE);
    localparam int CNT_BITS = $clog2(FILTER_SIZE + 1);
    localparam int KW       = $clog2(MAX_HASHES + 1);
    localparam int QB       = $clog2(2 * MAX_HASHES);

    t_cfg   cfg;
    t_state r_state;
    t_state n_state;

    logic [KIND_W-1:0]    r_kind;
    logic [SPAN-1:0]      r_v30;
    logic [KW-1:0]        r_k;
    logic [KW-1:0]        r_h;
    logic [CNT_BITS-1:0]  r_base;
    logic                 r_present;
    logic [AW-1:0]        r_idx;
    logic [AW-1:0]        r_clr_addr;
    logic                 r_clr_item;
    logic [CNT_BITS-1:0]  r_count;
    logic                 r_out_valid;
    logic                 r_out_present;
    logic [OUT_CNT_W-1:0] r_out_count;

    logic [CNT_BITS-1:0]  part_tab [MAX_HASHES + 1];
    logic [CNT_BITS-1:0]  part;
    logic [LINE_BITS-1:0] shifted;
    logic [HC_W:0]        hc_wide;
    logic [KW-1:0]        k_eff;
    logic [AW-1:0]        idx;
    logic [31:0]          cnt_wide;
    logic                 accept;
    logic                 out_free;
    logic                 clr_last;
    logic                 last_hash;

    logic                 in_ready;
    logic                 idx_load;
    logic                 mem_en;
    logic                 mem_we;
    logic                 mem_wdata;
    logic [AW-1:0]        mem_addr;
    logic                 mem_rdata;

    for (genvar gi = 0; gi <= MAX_HASHES; gi++) begin : g_part
        localparam int DIV = (gi == 0) ? 1 : gi;
        assign part_tab[gi] = CNT_BITS'(FILTER_SIZE / DIV);
    end

    bbf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bbf_index #(
        .IDX_BITS (IDX_BITS),
        .AW       (AW),
        .KW       (KW),
        .PB       (CNT_BITS),
        .QB       (QB)
    ) u_index (
        .i_clk    (i_clk),
        .i_load   (idx_load),
        .i_v30    (r_v30),
        .i_h      (r_h),
        .i_k      (r_k),
        .i_part   (part),
        .i_base   (r_base),
        .i_banked (cfg.banked_mode),
        .o_idx    (idx)
    );

    bbf_bitmem #(
        .DEPTH (FILTER_SIZE),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign hc_wide   = {1'b0, cfg.hash_count};
    assign k_eff     = (hc_wide > (HC_W + 1)'(MAX_HASHES)) ? KW'(MAX_HASHES) : KW'(hc_wide);
    assign shifted   = i_item.line_number >> cfg.skip_bits;
    assign part      = part_tab[r_k];
    assign accept    = i_item.valid && in_ready;
    assign out_free  = !r_out_valid || o_result.ready;
    assign clr_last  = (r_clr_addr == AW'(FILTER_SIZE - 1));
    assign last_hash = (r_h == KW'(r_k - KW'(1)));
    assign cnt_wide  = 32'(r_count);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    priority if (i_item.kind == KIND_CLEAR) begin
                        n_state = S_CLEAR;
                    end else if ((i_item.kind == KIND_INSERT || i_item.kind == KIND_QUERY)
                                 && k_eff != '0) begin
                        n_state = S_HASH;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CLEAR: begin
                if (clr_last) begin
                    n_state = r_clr_item ? S_DONE : S_IDLE;
                end
            end
            S_HASH:  n_state = S_READ;
            S_READ:  n_state = S_CHECK;
            S_CHECK: n_state = last_hash ? S_DONE : S_HASH;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        idx_load  = 1'b0;
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = 1'b0;
        mem_addr  = r_idx;
        unique case (r_state)
            S_IDLE:  in_ready = 1'b1;
            S_CLEAR: begin
                mem_en   = 1'b1;
                mem_we   = 1'b1;
                mem_addr = r_clr_addr;
            end
            S_HASH:  idx_load = 1'b1;
            S_READ: begin
                mem_en   = 1'b1;
                mem_addr = idx;
            end
            S_CHECK: begin
                mem_en    = (r_kind == KIND_INSERT) && !mem_rdata;
                mem_we    = mem_en;
                mem_wdata = 1'b1;
            end
            S_DONE:  ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_clr_item  <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && accept) begin
                r_clr_addr <= '0;
                r_clr_item <= 1'b1;
            end else if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (clr_last) begin
                    r_count <= '0;
                end
            end
            if (r_state == S_CHECK && r_kind == KIND_INSERT && !mem_rdata) begin
                r_count <= r_count + CNT_BITS'(1);
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && accept) begin
            r_kind    <= i_item.kind;
            r_v30     <= shifted[SPAN-1:0];
            r_k       <= k_eff;
            r_h       <= '0;
            r_base    <= '0;
            r_present <= 1'b1;
        end
        if (r_state == S_READ) begin
            r_idx <= idx;
        end
        if (r_state == S_CHECK) begin
            r_h    <= r_h + KW'(1);
            r_base <= r_base + part;
            if (r_kind == KIND_QUERY && !mem_rdata) begin
                r_present <= 1'b0;
            end
        end
        if (r_state == S_DONE && out_free) begin
            r_out_present <= (r_kind == KIND_QUERY) && r_present;
            r_out_count   <= cnt_wide[OUT_CNT_W-1:0];
        end
    end

    assign i_item.ready           = in_ready;
    assign o_result.valid         = r_out_valid;
    assign o_result.maybe_present = r_out_present;
    assign o_result.set_bit_count = r_out_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(FILTER_SIZE))
        else $error("set bit count above filter size");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_CLEAR |=> (r_count == $past(r_count)
                                || r_count == $past(r_count) + CNT_BITS'(1)))
        else $error("set bit count moved by more than one");

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && clr_last) |=> r_count == '0)
        else $error("count not zero after clearing pass");

    a_hash_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HASH || r_state == S_READ || r_state == S_CHECK) |-> r_h < r_k)
        else $error("hash number beyond hash count");

    a_present_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free && r_kind != KIND_QUERY) |=> !r_out_present)
        else $error("maybe_present set on a non-query item");
endmodule
